>>> sv/sba_pkg.sv
// shared types and constants for the slot bitmap allocator
// no dependencies; imported by the core and the testbench
package sba_pkg;

  localparam int NUM_SLOTS_DEF = 4096;
  localparam int WORD_BITS_DEF = 32;
  localparam int SLOT_IDX_W    = 12;
  localparam int COUNT_W       = 13;
  localparam int AGE_W         = 8;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  typedef struct packed {
    op_t              opcode;
    logic [AGE_W-1:0] lifetime;
  } in_beat_t;

  typedef struct packed {
    logic                  granted;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [COUNT_W-1:0]    freed_count;
    logic [COUNT_W-1:0]    live_count;
  } out_beat_t;

endpackage

>>> sv/sba_ram.sv
// simple dual-port ram: one write port, one read port with registered data
// used for the bitmap words and for the per-slot age and lifetime
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sba_lowbit.sv
// lowest set bit finder over one bitmap word
// shared by the allocate scan and the tick walk; no package needed
module sba_lowbit #(
  parameter int W  = 32,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign found = |vec;

endmodule

>>> sv/slot_bitmap_allocator_with_lifetime_core.sv
// slot allocator top level: sequencer around the bitmap ram, the slot ram and
// the shared lowest-bit finder; uses sba_pkg, sba_ram, sba_lowbit
// after reset a clearing pass zeroes the bitmap, in_ready low meanwhile
// count: goes straight to the result; clear: a clearing pass over the bitmap, then the result
// allocate: reads and scans bitmap words in turn up to the first non-full word, then the result
// tick: reads every bitmap word and ages each live slot in it, then the result; one item at a time
module slot_bitmap_allocator_with_lifetime_core #(
  parameter int NUM_SLOTS = sba_pkg::NUM_SLOTS_DEF,
  parameter int WORD_BITS = sba_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sba_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sba_pkg::out_beat_t out_data
);

  import sba_pkg::*;

  localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = $clog2(NUM_SLOTS);
  localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int LAST_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
  localparam int SMEM_W    = 2 * AGE_W;
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  typedef enum logic [6:0] {
    S_WIPE = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_WORD = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_AGE  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [AGE_W-1:0]      life_r, life_nxt;
  logic [WIDX_W-1:0]     widx_r, widx_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [WORD_BITS-1:0]  pend_r, pend_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [CNT_W-1:0]      freed_r, freed_nxt;
  logic                  granted_r, granted_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic                  reply_r, reply_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r, out_data_nxt;

  logic                  bm_we;
  logic [WIDX_W-1:0]     bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0]  bm_wdata, bm_rdata;
  logic                  sm_we;
  logic [ADDR_W-1:0]     sm_waddr, sm_raddr;
  logic [SMEM_W-1:0]     sm_wdata, sm_rdata;

  logic                  is_last;
  logic [WORD_BITS-1:0]  vmask, find_vec, fmask, bmask;
  logic                  fnd;
  logic [BIT_W-1:0]      fbit;
  logic [ADDR_W-1:0]     slot_addr, age_addr;
  logic [AGE_W:0]        age_inc;
  logic                  expire;

  sba_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS), .AW(WIDX_W)) u_bitmap (
    .clk  (clk),
    .we   (bm_we),
    .waddr(bm_waddr),
    .wdata(bm_wdata),
    .raddr(bm_raddr),
    .rdata(bm_rdata)
  );

  sba_ram #(.WIDTH(SMEM_W), .DEPTH(NUM_SLOTS), .AW(ADDR_W)) u_slot_ram (
    .clk  (clk),
    .we   (sm_we),
    .waddr(sm_waddr),
    .wdata(sm_wdata),
    .raddr(sm_raddr),
    .rdata(sm_rdata)
  );

  sba_lowbit #(.W(WORD_BITS), .IW(BIT_W)) u_lowbit (
    .vec  (find_vec),
    .found(fnd),
    .idx  (fbit)
  );

  assign is_last   = (widx_r == WIDX_W'(NUM_WORDS - 1));
  assign vmask     = is_last ? LAST_MASK : {WORD_BITS{1'b1}};
  assign find_vec  = (op_r == OP_ALLOC) ? (~word_r & vmask) : pend_r;
  assign fmask     = WORD_BITS'(1) << fbit;
  assign bmask     = WORD_BITS'(1) << bit_r;
  assign slot_addr = ADDR_W'(base_r + BASE_W'(fbit));
  assign age_addr  = ADDR_W'(base_r + BASE_W'(bit_r));
  assign age_inc   = {1'b0, sm_rdata[SMEM_W-1:AGE_W]} + (AGE_W + 1)'(1);
  assign expire    = (age_inc >= {1'b0, sm_rdata[AGE_W-1:0]});

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    life_nxt      = life_r;
    widx_nxt      = widx_r;
    base_nxt      = base_r;
    word_nxt      = word_r;
    pend_nxt      = pend_r;
    bit_nxt       = bit_r;
    live_nxt      = live_r;
    freed_nxt     = freed_r;
    granted_nxt   = granted_r;
    idx_nxt       = idx_r;
    reply_nxt     = reply_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    bm_we         = 1'b0;
    bm_waddr      = widx_r;
    bm_wdata      = word_r;
    bm_raddr      = widx_r;
    sm_we         = 1'b0;
    sm_waddr      = slot_addr;
    sm_wdata      = {AGE_W'(0), life_r};
    sm_raddr      = slot_addr;
    unique case (state_r)
      S_WIPE: begin
        bm_we    = 1'b1;
        bm_wdata = '0;
        if (is_last) begin
          widx_nxt  = '0;
          reply_nxt = 1'b0;
          state_nxt = reply_r ? S_DONE : S_IDLE;
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.opcode;
          life_nxt    = in_data.lifetime;
          granted_nxt = 1'b0;
          idx_nxt     = '0;
          freed_nxt   = '0;
          widx_nxt    = '0;
          base_nxt    = '0;
          unique case (in_data.opcode)
            OP_CLEAR: begin
              live_nxt  = '0;
              reply_nxt = 1'b1;
              state_nxt = S_WIPE;
            end
            OP_COUNT: state_nxt = S_DONE;
            default:  state_nxt = S_RD;
          endcase
        end
      end
      S_RD: state_nxt = S_WORD;
      S_WORD: begin
        word_nxt  = bm_rdata;
        pend_nxt  = bm_rdata;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (op_r == OP_ALLOC && fnd) begin
          bm_we       = 1'b1;
          bm_wdata    = word_r | fmask;
          sm_we       = 1'b1;
          live_nxt    = live_r + CNT_W'(1);
          granted_nxt = 1'b1;
          idx_nxt     = SLOT_IDX_W'(slot_addr);
          state_nxt   = S_DONE;
        end else if (op_r != OP_ALLOC && fnd) begin
          pend_nxt  = pend_r & ~fmask;
          bit_nxt   = fbit;
          state_nxt = S_AGE;
        end else begin
          // word done: tick writes back what it freed
          bm_we = (op_r != OP_ALLOC);
          if (is_last) begin
            state_nxt = S_DONE;
          end else begin
            widx_nxt  = widx_r + WIDX_W'(1);
            base_nxt  = base_r + BASE_W'(WORD_BITS);
            state_nxt = S_RD;
          end
        end
      end
      S_AGE: begin
        sm_waddr = age_addr;
        if (expire) begin
          word_nxt  = word_r & ~bmask;
          freed_nxt = freed_r + CNT_W'(1);
          if (live_r != '0) begin
            live_nxt = live_r - CNT_W'(1);
          end
        end else begin
          sm_we    = 1'b1;
          sm_wdata = {age_inc[AGE_W-1:0], sm_rdata[AGE_W-1:0]};
        end
        state_nxt = S_SCAN;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.granted     = granted_r;
          out_data_nxt.slot_index  = idx_r;
          out_data_nxt.freed_count = COUNT_W'(freed_r);
          out_data_nxt.live_count  = COUNT_W'(live_r);
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_WIPE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      widx_r      <= '0;
      live_r      <= '0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_COUNT;
    end else begin
      state_r     <= state_nxt;
      widx_r      <= widx_nxt;
      live_r      <= live_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    life_r     <= life_nxt;
    base_r     <= base_nxt;
    word_r     <= word_nxt;
    pend_r     <= pend_nxt;
    bit_r      <= bit_nxt;
    freed_r    <= freed_nxt;
    granted_r  <= granted_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(NUM_SLOTS))
    else $error("live count above slot count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && op_r == OP_ALLOC && fnd |-> $onehot(fmask & ~word_r & vmask))
    else $error("grant of a used or slack slot");

  a_expire_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AGE |-> (word_r & bmask) != '0)
    else $error("aging a slot that is not used");

  a_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.granted && out_data.freed_count != '0))
    else $error("grant and freed count in one beat");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for slot_bitmap_allocator_with_lifetime_core: directed, fill-to-full and random
// allocate, tick, clear and count beats, each result checked against a behavioral slot pool
// depends on sba_pkg and the core rtl only
module tb_top;
  import sba_pkg::*;

  localparam int QUIET_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 1200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  in_beat_t  op_stream_q[$];
  out_beat_t pool_results_q[$];

  bit   [NUM_SLOTS_DEF-1:0] slot_taken;
  logic [AGE_W-1:0]         age_of  [NUM_SLOTS_DEF];
  logic [AGE_W-1:0]         life_of [NUM_SLOTS_DEF];
  int                       live_slots = 0;

  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  bit idle_on   = 1'b1;
  int gap_left     = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int miss_count   = 0;

  slot_bitmap_allocator_with_lifetime_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_beat_t pool_step(in_beat_t beat);
    out_beat_t res;
    int        s;
    int        freed;
    bit        found;
    bit [8:0]  next_age;
    res   = '0;
    freed = 0;
    found = 1'b0;
    case (beat.opcode)
      OP_ALLOC: begin
        for (s = 0; s < NUM_SLOTS_DEF && !found; s++) begin
          if (!slot_taken[s]) begin
            found          = 1'b1;
            slot_taken[s]  = 1'b1;
            age_of[s]      = '0;
            life_of[s]     = beat.lifetime;
            live_slots++;
            res.granted    = 1'b1;
            res.slot_index = s[SLOT_IDX_W-1:0];
          end
        end
      end
      OP_TICK: begin
        for (s = 0; s < NUM_SLOTS_DEF; s++) begin
          if (slot_taken[s]) begin
            next_age = {1'b0, age_of[s]} + 9'd1;
            if (next_age >= {1'b0, life_of[s]}) begin
              slot_taken[s] = 1'b0;
              freed++;
              if (live_slots > 0) live_slots--;
            end else begin
              age_of[s] = next_age[AGE_W-1:0];
            end
          end
        end
      end
      OP_CLEAR: begin
        slot_taken = '0;
        live_slots = 0;
      end
      default: ;
    endcase
    res.freed_count = freed[COUNT_W-1:0];
    res.live_count  = live_slots[COUNT_W-1:0];
    return res;
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 8) : 0;
  endfunction

  function automatic logic [7:0] pick_lifetime();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'($urandom_range(0, 3));
    if (r < 8) return 8'($urandom_range(1, 20));
    if (r == 8) return 8'($urandom_range(21, 254));
    return 8'($urandom);
  endfunction

  task automatic push_op(op_t op, logic [7:0] life);
    in_beat_t beat;
    beat.opcode   = op;
    beat.lifetime = life;
    op_stream_q.push_back(beat);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (op_stream_q.size() != 0 || pool_results_q.size() != 0);
    @(posedge clk);
  endtask

  // accepted beats are predicted and checked here
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pool_results_q.push_back(pool_step(op_stream_q.pop_front()));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (pool_results_q.size() == 0) begin
          if (miss_count < 10)
            $display("unexpected result beat: g=%0d idx=%0d freed=%0d live=%0d",
                     out_data.granted, out_data.slot_index, out_data.freed_count,
                     out_data.live_count);
          miss_count++;
        end else begin
          want = pool_results_q.pop_front();
          if (out_data.granted !== want.granted || out_data.slot_index !== want.slot_index ||
              out_data.freed_count !== want.freed_count ||
              out_data.live_count !== want.live_count) begin
            if (miss_count < 10)
              $display("mismatch: exp g=%0d idx=%0d freed=%0d live=%0d, got g=%0d idx=%0d %s",
                       want.granted, want.slot_index, want.freed_count, want.live_count,
                       out_data.granted, out_data.slot_index,
                       $sformatf("freed=%0d live=%0d", out_data.freed_count,
                                 out_data.live_count));
            miss_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        gap_left = draw_wait();
      end
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (op_stream_q.size() > 0) begin
        in_data  <= op_stream_q[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        hold_left = draw_wait();
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int sent;
    int kind;
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lifetime is ignored outside allocate
    push_op(OP_COUNT, 8'hFF);
    push_op(OP_TICK, 8'hFF);
    push_op(OP_ALLOC, 8'h00);
    push_op(OP_ALLOC, 8'hFF);
    push_op(OP_ALLOC, 8'h01);
    push_op(OP_ALLOC, 8'h02);
    push_op(OP_ALLOC, 8'hAA);
    push_op(OP_ALLOC, 8'h55);
    push_op(OP_TICK, 8'h00);
    push_op(OP_ALLOC, 8'h03);
    push_op(OP_TICK, 8'h81);
    push_op(OP_COUNT, 8'h5A);
    push_op(OP_CLEAR, 8'hA5);
    push_op(OP_COUNT, 8'h00);
    push_op(OP_TICK, 8'h7F);
    push_op(OP_ALLOC, 8'h00);
    push_op(OP_ALLOC, 8'h00);
    push_op(OP_TICK, 8'h00);
    push_op(OP_CLEAR, 8'h00);
    settle();

    // fill every slot, then allocate while full and expire the whole pool
    idle_on = 1'b0;
    push_op(OP_CLEAR, 8'h00);
    repeat (NUM_SLOTS_DEF) push_op(OP_ALLOC, 8'($urandom_range(0, 1)));
    push_op(OP_ALLOC, 8'($urandom));
    push_op(OP_COUNT, 8'($urandom));
    push_op(OP_TICK, 8'($urandom));
    push_op(OP_COUNT, 8'($urandom));
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 19);
      if (kind < 12) begin
        n = $urandom_range(1, 24);
        repeat (n) push_op(OP_ALLOC, pick_lifetime());
        sent += n;
        n = $urandom_range(1, 6);
        repeat (n) begin
          push_op(OP_TICK, 8'($urandom));
          sent++;
          if ($urandom_range(0, 3) == 0) begin
            push_op(OP_COUNT, 8'($urandom));
            sent++;
          end
        end
      end else if (kind < 17) begin
        n = $urandom_range(1, 10);
        repeat (n) push_op(op_t'($urandom_range(0, 3)), 8'($urandom));
        sent += n;
      end else begin
        push_op(OP_CLEAR, 8'($urandom));
        push_op(OP_COUNT, 8'($urandom));
        sent += 2;
      end
      if ($urandom_range(0, 9) == 0) settle();
    end

    settle();
    repeat (40) @(posedge clk);
    if (miss_count == 0 && pool_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
